// ----- rtl/core/apwa_pkg.sv -----
// Shared constants, types and result codes of the ADC packet waveform assembler.
package apwa_pkg;

    localparam int CHANNELS            = 16;
    localparam int SAMPLES_PER_SEGMENT = 512;
    localparam int HEADER_BYTES        = 16;

    localparam int POS_W    = 10;
    localparam int POS_MAX  = (1 << POS_W) - 1;
    localparam int PAIRS    = SAMPLES_PER_SEGMENT / 2;
    localparam int PAIR_W   = $clog2(PAIRS + 1);
    localparam int HALVES_W = 32;
    localparam int CHAN_W   = 4;
    localparam int IDX_W    = 10;
    localparam int SAMPLE_W = 12;
    localparam int FRAME_W  = 16;

    localparam logic [HALVES_W-1:0] HALVES_FULL =
        HALVES_W'((64'd1 << (2 * CHANNELS)) - 64'd1);

    // Header byte offsets.
    localparam logic [POS_W-1:0] POS_ADC_CHAN = POS_W'(7);
    localparam logic [POS_W-1:0] POS_SEG_HI   = POS_W'(8);
    localparam logic [POS_W-1:0] POS_SEG_LO   = POS_W'(9);
    localparam logic [POS_W-1:0] POS_SEQ_HI   = POS_W'(10);
    localparam logic [POS_W-1:0] POS_SEQ_LO   = POS_W'(11);
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HEADER_BYTES);

    // Queue between the parser and the output side.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_PAIR  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_SHORT = 2'd2,
        KIND_BADCH = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [CHAN_W-1:0]    channel;
        logic [IDX_W-1:0]     sample_index;
        logic [SAMPLE_W-1:0]  sample_even;
        logic [SAMPLE_W-1:0]  sample_odd;
        logic [FRAME_W-1:0]   frame_number;
    } result_t;

    // Everything one byte produces: an optional pair or bad-channel result,
    // followed by an optional end-of-packet result.
    typedef struct packed {
        logic    has_a;
        logic    has_b;
        result_t a;
        result_t b;
    } entry_t;

endpackage

// ----- rtl/core/adc_packet_waveform_assembler.sv -----
// Top level of the ADC packet waveform assembler: parser, result queue and output side.
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  -------------------------------------------
//  s_axis    in         s_tvalid / s_tready  tdata: data_byte; tuser: first_byte;
//                                            tlast: last_byte
//  m_axis    out        m_tvalid / m_tready  tdata: channel, sample_index, sample_even,
//                                            sample_odd, frame_number; tuser: kind;
//                                            tlast: run_end
//
// The parser takes one packet byte per cycle and resolves its header, lock and
// unpacking decisions in that same cycle. Each byte that yields results puts one
// entry into a four-deep queue, and the output side sends one result per cycle
// from it while m_tready is high, so the two results of a byte leave one after
// the other. The input stalls only while the queue is full. Results pass through
// the queue memory and then the output register before they reach m_axis.
// Reset clears all parser state, the frame lock and the channel map.
module adc_packet_waveform_assembler
    import apwa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first_byte
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [3:0] channel, [13:4] sample_index,
                                   // [25:14] sample_even, [37:26] sample_odd,
                                   // [53:38] frame_number, [55:54] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic    accept;
    logic    push;
    entry_t  push_entry;
    logic    full;
    logic    pop;
    entry_t  head;
    logic    head_valid;
    result_t out_result;

    // A byte is taken whenever the queue has room for what it may produce.
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    apwa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .first_byte (s_tuser[0]),
        .last_byte  (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    apwa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    apwa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (out_result),
        .out_last   (m_tlast)
    );

    // The kind travels in tuser; the remaining fields are packed into tdata.
    assign m_tuser = out_result.kind;
    assign m_tdata = {2'b00,
                      out_result.frame_number,
                      out_result.sample_odd,
                      out_result.sample_even,
                      out_result.sample_index,
                      out_result.channel};

endmodule

// ----- rtl/core/apwa_front.sv -----
// Packet parser: header capture, frame lock, sample unpacking and channel map.
module apwa_front
    import apwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       push,
    output entry_t     push_entry
);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [1:0]          phase_reg, phase_next;
    logic [PAIR_W-1:0]   pair_reg, pair_next;
    logic [7:0]          acb_reg, acb_next;
    logic [15:0]         seg_reg, seg_next;
    logic [15:0]         seq_reg, seq_next;
    logic                locked_reg, locked_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [HALVES_W-1:0] halves_reg, halves_next;
    logic [15:0]         held_reg, held_next;
    logic                dropped_reg, dropped_next;

    logic [POS_W-1:0]    p;
    logic [1:0]          phase;
    logic [PAIR_W-1:0]   pair;
    logic                dropped;
    logic [7:0]          ch;
    logic [4:0]          half_bit;
    logic [IDX_W-1:0]    base;
    entry_t              ent;

    always_comb
    begin
        p       = first_byte ? '0 : pos_reg;
        phase   = first_byte ? '0 : phase_reg;
        pair    = first_byte ? '0 : pair_reg;
        dropped = first_byte ? 1'b0 : dropped_reg;
        ch      = {1'b0, acb_reg[7:4], 3'b000} + {4'b0000, acb_reg[3:0]};
        half_bit = {ch[3:0], (seg_reg != 16'd0)};
        base    = (seg_reg != 16'd0) ? IDX_W'(SAMPLES_PER_SEGMENT) : '0;

        pos_next     = p;
        phase_next   = phase;
        pair_next    = pair;
        acb_next     = acb_reg;
        seg_next     = seg_reg;
        seq_next     = seq_reg;
        locked_next  = locked_reg;
        frame_next   = frame_reg;
        halves_next  = halves_reg;
        held_next    = held_reg;
        dropped_next = dropped;
        ent          = '0;

        if (p < POS_PAYLOAD)
        begin
            if (p == POS_ADC_CHAN)
                acb_next = data_byte;
            else if (p == POS_SEG_HI)
                seg_next = {data_byte, 8'h00};
            else if (p == POS_SEG_LO)
                seg_next = {seg_reg[15:8], data_byte};
            else if (p == POS_SEQ_HI)
                seq_next = {data_byte, 8'h00};
            else if (p == POS_SEQ_LO)
                seq_next = {seq_reg[15:8], data_byte};
        end
        else if (!dropped)
        begin
            if (p == POS_PAYLOAD)
            begin
                if (!locked_reg)
                begin
                    locked_next = 1'b1;
                    frame_next  = seq_reg;
                end
                if (seq_reg != frame_next)
                    dropped_next = 1'b1;
                else if (ch >= 8'(CHANNELS))
                begin
                    dropped_next         = 1'b1;
                    ent.has_a            = 1'b1;
                    ent.a.kind           = KIND_BADCH;
                    ent.a.channel        = ch[3:0];
                end
            end
            if (!dropped_next && (pair < PAIR_W'(PAIRS)))
            begin
                unique case (phase)
                    2'd0: held_next = {8'h00, data_byte};
                    2'd1: held_next = {data_byte, held_reg[7:0]};
                    default:
                    begin
                        ent.has_a          = 1'b1;
                        ent.a.kind         = KIND_PAIR;
                        ent.a.channel      = ch[3:0];
                        ent.a.sample_index = base + IDX_W'({pair, 1'b0});
                        ent.a.sample_even  = {held_reg[11:8], held_reg[7:0]};
                        ent.a.sample_odd   = {data_byte, held_reg[15:12]};
                    end
                endcase
            end
        end

        if (last_byte)
        begin
            if (p < POS_PAYLOAD)
            begin
                ent.has_b   = 1'b1;
                ent.b.kind  = KIND_SHORT;
                locked_next = 1'b0;
                halves_next = '0;
            end
            else if (!dropped_next)
            begin
                halves_next = halves_reg | (HALVES_W'(1) << half_bit);
                if ((halves_next & HALVES_FULL) == HALVES_FULL)
                begin
                    ent.has_b   = 1'b1;
                    ent.b.kind  = KIND_DONE;
                    locked_next = 1'b0;
                    halves_next = '0;
                end
            end
            pos_next     = '0;
            phase_next   = '0;
            pair_next    = '0;
            dropped_next = 1'b0;
        end
        else if (p != POS_W'(POS_MAX))
        begin
            pos_next = p + POS_W'(1);
            if (p >= POS_PAYLOAD)
            begin
                if (phase == 2'd2)
                begin
                    phase_next = 2'd0;
                    if (pair < PAIR_W'(PAIRS))
                        pair_next = pair + PAIR_W'(1);
                end
                else
                    phase_next = phase + 2'd1;
            end
        end

        ent.a.frame_number = frame_next;
        ent.b.frame_number = frame_next;
    end

    assign push       = accept && (ent.has_a || ent.has_b);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= '0;
            pair_reg    <= '0;
            acb_reg     <= '0;
            seg_reg     <= '0;
            seq_reg     <= '0;
            locked_reg  <= 1'b0;
            frame_reg   <= '0;
            halves_reg  <= '0;
            held_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            pair_reg    <= pair_next;
            acb_reg     <= acb_next;
            seg_reg     <= seg_next;
            seq_reg     <= seq_next;
            locked_reg  <= locked_next;
            frame_reg   <= frame_next;
            halves_reg  <= halves_next;
            held_reg    <= held_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

// ----- rtl/core/apwa_fifo.sv -----
// Short result queue between the parser and the output side.
module apwa_fifo
    import apwa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   head_valid
);

    entry_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full       = (count_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (FIFO_PTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (FIFO_PTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/apwa_back.sv -----
// Output side: splits queued entries into single results behind an output register.
module apwa_back
    import apwa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  head,
    input  logic    head_valid,
    output logic    pop,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_result,
    output logic    out_last
);

    logic    sel_b_reg, sel_b_next;
    logic    valid_reg, valid_next;
    result_t result_reg;
    logic    last_reg;
    logic    emit_b, cur_last, load;
    result_t cur;

    always_comb
    begin
        emit_b   = sel_b_reg || !head.has_a;
        cur      = emit_b ? head.b : head.a;
        cur_last = emit_b || !head.has_b;
        load     = head_valid && (!valid_reg || out_ready);
        pop      = load && cur_last;

        sel_b_next = sel_b_reg;
        if (load)
            sel_b_next = !cur_last;

        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= cur;
            last_reg   <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_b_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_b_reg <= sel_b_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign out_last   = last_reg;

endmodule
